>>> design/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Depends on nothing; tcw_sweep and text_console_writer refer to it by scoped names.
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Cell width and character codes
  localparam int         CELL_W       = 16;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] BLANK_BYTE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'd7;

  // Opcodes of an input item
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // One input item
  typedef struct packed {
    logic        opcode;
    logic [7:0]  character;
    logic        end_of_string;
    logic [10:0] read_index;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] hw_cursor_index;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_item_t;

  // Request from the control logic to the sweep engine
  typedef struct packed {
    logic       start;   // begin a sweep (taken only while the engine is idle)
    logic       scroll;  // 1: move rows up and blank the last; 0: blank all cells
    logic [7:0] color;   // attribute byte for blanked cells
  } sweep_cmd_t;

endpackage

>>> design/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/tcw_sweep.sv
// Sweep engine of the text console writer: clears the screen store after reset
// and scrolls it up one row. Uses tcw_pkg for the request type and constants.
module tcw_sweep #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tcw_pkg::sweep_cmd_t                 cmd,
  output logic                                busy,
  output logic                                ram_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]          ram_wdata,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]          ram_rdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [1:0] SW_IDLE = 2'd0;
  localparam logic [1:0] SW_COPY = 2'd1;
  localparam logic [1:0] SW_FILL = 2'd2;

  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FIRST_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);

  logic [1:0]        state;
  logic [ADDR_W-1:0] idx;
  logic              pipe_v;
  logic [ADDR_W-1:0] pipe_dst;
  logic [7:0]        color;

  // Advance through the copy and fill phases
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SW_IDLE;
      pipe_v <= 1'b0;
    end else begin
      pipe_v <= (state == SW_COPY);
      case (state)
        SW_IDLE: begin
          if (cmd.start) begin
            color <= cmd.color;
            idx   <= '0;
            state <= cmd.scroll ? SW_COPY : SW_FILL;
          end
        end
        SW_COPY: begin
          // read one row ahead now, write the cell back in the next cycle
          pipe_dst <= idx;
          if (idx == LAST_COPY) begin
            idx   <= FIRST_LAST;
            state <= SW_FILL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        SW_FILL: begin
          // hold the fill while the last copied cell drains
          if (!pipe_v) begin
            if (idx == LAST_CELL) begin
              state <= SW_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= SW_IDLE;
        end
      endcase
    end
  end

  // Drive the memory port
  always_comb begin
    busy      = (state != SW_IDLE);
    ram_raddr = idx + ADDR_W'(COLUMNS);
    ram_we    = pipe_v || (state == SW_FILL);
    ram_waddr = pipe_v ? pipe_dst : idx;
    ram_wdata = pipe_v ? ram_rdata : {color, tcw_pkg::BLANK_BYTE};
  end

endmodule

>>> design/text_console_writer.sv
// Top level of the text console writer: cursor control, item handshakes and
// the screen store. Depends on tcw_pkg, tcw_ram and tcw_sweep.
//
//   port group   direction   payload               transfer when
//   in_*         input       tcw_pkg::in_item_t    in_valid && !in_stall
//   out_*        output      tcw_pkg::out_item_t   out_valid && !out_stall
//   cfg_*        input       text_color byte       cfg_we
//
// A put goes from S_IDLE to S_EMIT; a read goes through S_READ first, as the
// memory read is registered. A put that scrolls also waits in S_SCROLL: the
// sweep engine copies one cell per cycle through the single memory port pair.
// After reset a clearing pass runs before the first item is taken; text_color
// writes are taken throughout.
// in_stall is high while an item is in work; a stalled result waits in the
// output register.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcw_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcw_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CMP_W  = ((ADDR_W > 11) ? ADDR_W : 11) + 1;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_IDLE   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]                 state;
  logic [ROW_W-1:0]           row;
  logic [COL_W-1:0]           col;
  logic [ADDR_W-1:0]          row_base;
  logic [ADDR_W-1:0]          hw_cursor;
  logic [7:0]                 text_color;
  logic                       rd_in_range;
  logic                       res_scrolled;
  logic [tcw_pkg::CELL_W-1:0] res_cell;

  logic                       accept;
  logic                       is_put;
  logic                       line_end;
  logic                       at_bottom;
  logic                       do_scroll;
  logic [ROW_W-1:0]           row_next;
  logic [COL_W-1:0]           col_next;
  logic [ADDR_W-1:0]          row_base_next;
  logic [ADDR_W-1:0]          hw_cursor_next;

  tcw_pkg::sweep_cmd_t        sweep_cmd;
  logic                       sweep_busy;
  logic                       sw_we;
  logic [ADDR_W-1:0]          sw_waddr;
  logic [tcw_pkg::CELL_W-1:0] sw_wdata;
  logic [ADDR_W-1:0]          sw_raddr;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // Take an item only in idle; one item is in work at a time
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_put   = (in_data.opcode == tcw_pkg::OP_PUT);

  // Work out the cursor move of a put
  always_comb begin
    line_end  = (in_data.character == tcw_pkg::NEWLINE_BYTE) ||
                (col == COL_W'(COLUMNS - 1));
    at_bottom = (row == ROW_W'(ROWS - 1));
    do_scroll = line_end && at_bottom;
    if (line_end && !at_bottom) begin
      row_next      = row + 1'b1;
      row_base_next = row_base + ADDR_W'(COLUMNS);
    end else begin
      row_next      = row;
      row_base_next = row_base;
    end
    col_next       = line_end ? '0 : col + 1'b1;
    hw_cursor_next = row_base_next + ADDR_W'(col_next);
  end

  // Start the clearing pass after reset, or a scroll after a put
  always_comb begin
    sweep_cmd.start  = (state == S_INIT) || (accept && is_put && do_scroll);
    sweep_cmd.scroll = (state != S_INIT);
    sweep_cmd.color  = (state == S_INIT) ? tcw_pkg::RESET_COLOR : text_color;
  end

  // Give the memory to the sweep engine while it runs
  always_comb begin
    if (sweep_busy) begin
      ram_we    = sw_we;
      ram_waddr = sw_waddr;
      ram_wdata = sw_wdata;
      ram_raddr = sw_raddr;
    end else begin
      ram_we    = accept && is_put && (in_data.character != tcw_pkg::NEWLINE_BYTE);
      ram_waddr = row_base + ADDR_W'(col);
      ram_wdata = {text_color, in_data.character};
      ram_raddr = ADDR_W'(in_data.read_index);
    end
  end

  // Sequence items, update the cursor and load results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      row        <= '0;
      col        <= '0;
      row_base   <= '0;
      hw_cursor  <= '0;
      text_color <= tcw_pkg::RESET_COLOR;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          state <= S_CLEAR;
        end
        S_CLEAR: begin
          if (!sweep_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (is_put) begin
              row          <= row_next;
              col          <= col_next;
              row_base     <= row_base_next;
              res_scrolled <= do_scroll;
              res_cell     <= '0;
              if (in_data.end_of_string) begin
                hw_cursor <= hw_cursor_next;
              end
              state <= do_scroll ? S_SCROLL : S_EMIT;
            end else begin
              rd_in_range  <= CMP_W'(in_data.read_index) < CMP_W'(CELLS);
              res_scrolled <= 1'b0;
              state        <= S_READ;
            end
          end
        end
        S_READ: begin
          res_cell <= rd_in_range ? ram_rdata : '0;
          state    <= S_EMIT;
        end
        S_SCROLL: begin
          if (!sweep_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.cursor_row      <= 5'(row);
            out_data.cursor_column   <= 7'(col);
            out_data.hw_cursor_index <= 11'(hw_cursor);
            out_data.cell_data       <= res_cell;
            out_data.scrolled        <= res_scrolled;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .cmd       (sweep_cmd),
    .busy      (sweep_busy),
    .ram_we    (sw_we),
    .ram_waddr (sw_waddr),
    .ram_wdata (sw_wdata),
    .ram_raddr (sw_raddr),
    .ram_rdata (ram_rdata)
  );

  // No item may enter while the sweep engine owns the memory
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> !accept)
    else $error("item transfer while sweep running");

  // Row base tracks the row
  a_row_base: assert property (@(posedge clk) disable iff (rst)
    row_base == ADDR_W'(row * COLUMNS))
    else $error("row base out of step with row");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (row <= ROW_W'(ROWS - 1)) && (col <= COL_W'(COLUMNS - 1)))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && accept && is_put && do_scroll) |=>
      (row == ROW_W'(ROWS - 1)) && (col == '0) && sweep_busy)
    else $error("scroll did not hold the cursor on the bottom row");

endmodule
